// ----- design/swm_pkg.sv -----
// shared types and constants for the sliding window minimum block
package swm_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int CFG_W        = 7;
  localparam int WIN_W        = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [PTR_W-1:0]               ptr_t;
  typedef logic [WIN_W-1:0]               win_t;
  typedef logic [CFG_W-1:0]               cfg_t;

  // contents of one cell, handed toward the front on a pop
  typedef struct packed {
    logic    valid;
    sample_t value;
  } cell_state_t;

  // per-step control broadcast to every cell
  typedef struct packed {
    logic    en;
    logic    clr;
    logic    flush;
    logic    shift;
    sample_t x;
  } cell_ctrl_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

// ----- design/swm_cell.sv -----
// one candidate cell of the monotonic queue
module swm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swm_pkg::cell_ctrl_t ctrl_i,
  input  swm_pkg::cell_state_t up_i,
  input  logic                prev_keep_i,
  output swm_pkg::cell_state_t cur_o,
  output logic                keep_o,
  output swm_pkg::sample_t    nxt_value_o
);
  import swm_pkg::*;

  logic        valid_q;
  sample_t     value_q;
  sample_t     src_value;
  logic        src_valid;
  logic        keep;
  cell_state_t cur_d;

  // entry after the optional front pop
  always_comb begin
    src_value = ctrl_i.shift ? up_i.value : value_q;
    src_valid = !ctrl_i.flush && (ctrl_i.shift ? up_i.valid : valid_q);
  end

  // keep entries not above the new sample, first dropped slot takes it
  always_comb begin
    keep        = src_valid && (src_value <= ctrl_i.x);
    cur_d.value = keep ? src_value : ctrl_i.x;
    cur_d.valid = keep || prev_keep_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.en) begin
      valid_q <= cur_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en && cur_d.valid) begin
      value_q <= cur_d.value;
    end
  end

  assign cur_o.valid = valid_q;
  assign cur_o.value = value_q;
  assign keep_o      = keep;
  assign nxt_value_o = cur_d.value;

endmodule

// ----- design/swm_ring.sv -----
// history ram holding the samples of the current window
module swm_ring (
  input  logic             clk_i,
  input  logic             we_i,
  input  swm_pkg::ptr_t    waddr_i,
  input  swm_pkg::sample_t wdata_i,
  input  logic             re_i,
  input  swm_pkg::ptr_t    raddr_i,
  output swm_pkg::sample_t rdata_o
);
  import swm_pkg::*;

  sample_t mem [MAX_WINDOW];
  sample_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/sliding_window_minimum.sv -----
// Sliding window minimum over a signed sample stream. Each item has an accept
// step and an update step: the accept step reads the sample leaving the
// window from the history RAM (registered read port), and the update step
// refreshes the row of MAX_WINDOW candidate cells, which drop larger entries
// in parallel and take the new sample. The input stalls until the item in
// flight has updated; a result waiting in the output register only delays
// the update if it is still held when the next item is ready to finish. A
// result is given once window_size samples have arrived since reset,
// restart or a window_size write; a window_size write restarts the sequence,
// 0 acts as 1 and values above MAX_WINDOW act as MAX_WINDOW.
module sliding_window_minimum (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  swm_pkg::sample_t sample_i,
  input  logic             restart_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output swm_pkg::sample_t window_min_o,
  input  logic             cfg_we_i,
  input  swm_pkg::cfg_t    cfg_wdata_i
);
  import swm_pkg::*;

  state_e  state_q, state_d;
  sample_t sample_q;
  logic    restart_q;
  cfg_t    win_q;
  ptr_t    ptr_q;
  win_t    seen_q;
  logic    out_valid_q;
  sample_t out_data_q;

  logic    in_accept;
  logic    finish;
  logic    step;
  win_t    w_eff;
  win_t    seen_eff;
  ptr_t    ptr_eff;
  win_t    ptr_inc;
  ptr_t    ptr_nxt;
  win_t    seen_nxt;
  logic    full_before;
  logic    emit;
  sample_t leaving;
  logic    shift;

  cell_ctrl_t  ctrl;
  cell_state_t cell_cur   [MAX_WINDOW];
  logic        cell_keep  [MAX_WINDOW];
  sample_t     cell_nxt   [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] valid_vec;

  // effective window length
  always_comb begin
    if (win_q == '0) begin
      w_eff = WIN_W'(1);
    end else if (int'(win_q) > MAX_WINDOW) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = WIN_W'(win_q);
    end
  end

  // state machine: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state machine: outputs
  always_comb begin
    in_stall_o = 1'b1;
    step       = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_EXEC: step       = finish;
      default: in_stall_o = 1'b1;
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign finish    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // input item register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q  <= sample_i;
      restart_q <= restart_i;
    end
  end

  // sequence bookkeeping for the item in flight
  always_comb begin
    seen_eff    = restart_q ? '0 : seen_q;
    ptr_eff     = restart_q ? '0 : ptr_q;
    full_before = seen_eff >= w_eff;
    seen_nxt    = full_before ? seen_eff : seen_eff + WIN_W'(1);
    emit        = seen_nxt >= w_eff;
    ptr_inc     = WIN_W'(ptr_eff) + WIN_W'(1);
    ptr_nxt     = (ptr_inc >= w_eff) ? '0 : ptr_inc[PTR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= CFG_W'(1);
      ptr_q  <= '0;
      seen_q <= '0;
    end else if (cfg_we_i) begin
      win_q  <= cfg_wdata_i;
      ptr_q  <= '0;
      seen_q <= '0;
    end else if (step) begin
      ptr_q  <= ptr_nxt;
      seen_q <= seen_nxt;
    end
  end

  // history of the window, read while the item is accepted
  swm_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (step),
    .waddr_i (ptr_eff),
    .wdata_i (sample_q),
    .re_i    (in_accept),
    .raddr_i (ptr_q),
    .rdata_o (leaving)
  );

  // pop the front when the leaving sample is the current minimum
  assign shift = !restart_q && full_before && cell_cur[0].valid &&
                 (cell_cur[0].value == leaving);

  always_comb begin
    ctrl.en    = step;
    ctrl.clr   = cfg_we_i;
    ctrl.flush = restart_q;
    ctrl.shift = shift;
    ctrl.x     = sample_q;
  end

  // row of candidate cells, front at index zero
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    cell_state_t up;
    logic        prev_keep;

    if (i == MAX_WINDOW - 1) begin : g_last
      assign up = '0;
    end else begin : g_mid
      assign up = cell_cur[i+1];
    end

    if (i == 0) begin : g_front
      assign prev_keep = 1'b1;
    end else begin : g_back
      assign prev_keep = cell_keep[i-1];
    end

    swm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .up_i        (up),
      .prev_keep_i (prev_keep),
      .cur_o       (cell_cur[i]),
      .keep_o      (cell_keep[i]),
      .nxt_value_o (cell_nxt[i])
    );

    assign valid_vec[i] = cell_cur[i].valid;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_data_q <= cell_nxt[0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_min_o = out_data_q;

  // occupied cells always form a run from the front
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + MAX_WINDOW'(1))) == '0)
    else $error("candidate cells not contiguous from the front");

  // after an update the front cell holds a candidate
  a_front_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !cfg_we_i) |=> cell_cur[0].valid)
    else $error("front cell empty after an item");

  // sample count never passes the window length
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= w_eff)
    else $error("sample count above window length");

  // ring pointer stays inside the window
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WIN_W'(ptr_q) < w_eff)
    else $error("ring pointer outside window");

endmodule

// ----- verif/sliding_window_minimum_tb.sv -----
// self-checking testbench for the sliding window minimum block
module sliding_window_minimum_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swm_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 6;
  localparam int RANDOM_ITEMS = 430;

  typedef enum logic [0:0] {
    ROW_ITEM,
    ROW_WIN
  } row_kind_e;

  typedef enum logic [1:0] {
    MODE_FULL,
    MODE_TIGHT,
    MODE_RAMP,
    MODE_EDGE
  } sample_mode_e;

  // one directed step: an item, or a window_size write carried in data
  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] data;
    logic        restart;
    logic        typed;
    sample_t     want;
  } plan_row_t;

  localparam int PLAN_LEN = 27;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // window of one after reset: each item is its own minimum
    '{ROW_ITEM, 16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
    '{ROW_ITEM, 16'h8000, 1'b0, 1'b1, 16'h8000},
    '{ROW_ITEM, 16'h0000, 1'b0, 1'b1, 16'h0000},
    '{ROW_ITEM, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF},
    '{ROW_ITEM, 16'h5555, 1'b1, 1'b1, 16'h5555},
    '{ROW_ITEM, 16'hAAAA, 1'b0, 1'b1, 16'hAAAA},
    // window of three: fill, slide, duplicates, extremes
    '{ROW_WIN,  16'd3,    1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'd5,    1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'd9,    1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'd7,    1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'd9,    1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'd9,    1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'd9,    1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'h8000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'h7FFF, 1'b0, 1'b0, 16'h0000},
    // restart mid-sequence, window refills
    '{ROW_ITEM, 16'd4,    1'b1, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'd3,    1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'd2,    1'b0, 1'b0, 16'h0000},
    // size zero acts as one
    '{ROW_WIN,  16'd0,    1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'h1234, 1'b0, 1'b1, 16'h1234},
    // size above the maximum saturates
    '{ROW_WIN,  16'd127,  1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'd100,  1'b0, 1'b0, 16'h0000},
    // window of two with equal values leaving
    '{ROW_WIN,  16'd2,    1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'hFFFB, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'hFFFB, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'd0,    1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, 16'd1,    1'b0, 1'b0, 16'h0000}
  };

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_stall_o;
  sample_t sample_i    = '0;
  logic    restart_i   = 1'b0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  sample_t window_min_o;
  logic    cfg_we_i    = 1'b0;
  cfg_t    cfg_wdata_i = '0;

  // predictor state
  sample_t cand_vals [MAX_WINDOW];
  int      cand_cnt;
  sample_t hist [MAX_WINDOW];
  int      hist_ptr;
  int      seen;
  cfg_t    win_reg;

  sample_t      mins_due [$];
  int           mismatch_cnt = 0;
  int           cycle_cnt    = 0;
  int           stall_left   = 0;
  bit           in_busy      = 1'b1;
  bit           out_busy     = 1'b1;
  sample_t      got_due;
  sample_t      ramp_val;
  int           ramp_dir;
  sample_mode_e mode;

  always #2 clk_i = ~clk_i;

  sliding_window_minimum dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .window_min_o (window_min_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  function automatic int draw_gap(input bit busy);
    if (!busy) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 13);
  endfunction

  function automatic int eff_window(input cfg_t v);
    if (v == 0) return 1;
    if (v > MAX_WINDOW) return MAX_WINDOW;
    return int'(v);
  endfunction

  function automatic void clear_seq();
    cand_cnt = 0;
    hist_ptr = 0;
    seen     = 0;
  endfunction

  // advance the window by one item, returns 1 when a minimum is due
  function automatic bit advance_window_min(input sample_t x, input logic rs,
                                            output sample_t m);
    int w;
    w = eff_window(win_reg);
    m = '0;
    if (rs) clear_seq();
    if (hist_ptr >= w) hist_ptr = 0;
    // drop the leaving item from the front
    if (seen >= w && cand_cnt > 0 && cand_vals[0] == hist[hist_ptr]) begin
      for (int i = 0; i < cand_cnt - 1; i++) cand_vals[i] = cand_vals[i + 1];
      cand_cnt--;
    end
    // pop larger candidates from the back, then append
    while (cand_cnt > 0 && cand_vals[cand_cnt - 1] > x) cand_cnt--;
    if (cand_cnt < MAX_WINDOW) begin
      cand_vals[cand_cnt] = x;
      cand_cnt++;
    end
    hist[hist_ptr] = x;
    hist_ptr++;
    if (hist_ptr >= w) hist_ptr = 0;
    if (seen < w) seen++;
    if (seen >= w && cand_cnt > 0) begin
      m = cand_vals[0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic sample_t gen_sample(input sample_mode_e md);
    // occasional full-range noise in every mode
    if ($urandom_range(0, 9) == 0) return sample_t'($urandom_range(0, 65535));
    case (md)
      MODE_TIGHT: return sample_t'($urandom_range(0, 6) - 3);
      MODE_RAMP: begin
        ramp_val = ramp_val + sample_t'(ramp_dir * $urandom_range(0, 3));
        return ramp_val;
      end
      MODE_EDGE: begin
        case ($urandom_range(0, 6))
          0: return 16'sh8000;
          1: return 16'sh8001;
          2: return -16'sd1;
          3: return 16'sd0;
          4: return 16'sd1;
          5: return 16'sh7FFE;
          default: return 16'sh7FFF;
        endcase
      end
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // drive one item and record its minimum on acceptance
  task automatic send_sample(input sample_t s, input logic rs, input bit typed,
                             input sample_t want);
    int      gap;
    sample_t m;
    gap = draw_gap(in_busy);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    restart_i  <= rs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (advance_window_min(s, rs, m)) mins_due = {mins_due, (typed ? want : m)};
  endtask

  // wait until every due minimum has come out and the block has settled
  task automatic drain();
    while (mins_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_window(input cfg_t v);
    in_valid_i <= 1'b0;
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_reg = v;
    clear_seq();
  endtask

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mins_due.size() == 0) begin
        $error("window_min: no item expected, got %0d", window_min_o);
        mismatch_cnt++;
      end else begin
        got_due = mins_due[0];
        mins_due.delete(0);
        if (window_min_o !== got_due) begin
          $error("window_min: expected %0d, got %0d", got_due, window_min_o);
          mismatch_cnt++;
        end
      end
      stall_left = draw_gap(out_busy);
      out_stall_i <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= (stall_left != 0);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    int   sent;
    int   len;
    int   ew;
    int   roll;
    int   rs_rate;
    cfg_t wv;

    win_reg  = 7'd1;
    ramp_val = '0;
    ramp_dir = 1;
    mode     = MODE_FULL;
    clear_seq();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_WIN) set_window(cfg_t'(PLAN[i].data));
      else send_sample(sample_t'(PLAN[i].data), PLAN[i].restart, PLAN[i].typed,
                       PLAN[i].want);
    end

    // random phases, each with its own window size and traffic shape
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 19);
      if (roll < 11)      wv = cfg_t'($urandom_range(1, 8));
      else if (roll < 14) wv = cfg_t'($urandom_range(9, 63));
      else if (roll < 16) wv = cfg_t'(MAX_WINDOW);
      else if (roll < 17) wv = '0;
      else if (roll < 18) wv = cfg_t'($urandom_range(65, 127));
      else                wv = cfg_t'($urandom_range(0, 127));
      set_window(wv);
      ew = eff_window(wv);
      // short broken sequences now and then, mostly full windows
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, ew);
      else len = ew + $urandom_range(3, 30);
      rs_rate  = ($urandom_range(0, 9) < 7) ? 0 : 12;
      mode     = sample_mode_e'($urandom_range(0, 3));
      ramp_val = sample_t'($urandom_range(0, 65535));
      ramp_dir = $urandom_range(0, 1) ? 1 : -1;
      in_busy  = $urandom_range(0, 3) != 0;
      out_busy = $urandom_range(0, 3) != 0;
      repeat (len) begin
        send_sample(gen_sample(mode),
                    (rs_rate != 0) && ($urandom_range(1, rs_rate) == 1), 1'b0, '0);
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    drain();
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
